/* rtl/mcch_pkg.sv */
`default_nettype none

package mcch_pkg;

  localparam int MAX_CHANNELS = 256;
  localparam int CH_MIN       = 3;

  localparam int CNT_W     = 9;
  localparam int CHAN_W    = 8;
  localparam int RAND_W    = 16;
  localparam int HOP_W     = 32;
  localparam int ROUND_W   = 10;
  localparam int BOUND_W   = CNT_W + 1;
  localparam int TRIAL_W   = 5;
  localparam int DIV_CNT_W = $clog2(RAND_W + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic OP_INIT = 1'b0;
  localparam logic OP_HOP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MODE  = 1'b1;

  localparam logic [CNT_W-1:0]  CHANNEL_COUNT_RST = 9'd16;
  localparam logic [CHAN_W-1:0] RATE_RST          = 8'd2;
  localparam logic [CHAN_W-1:0] RATE_MIN          = 8'd2;

  typedef struct packed {
    logic              op;
    logic [CNT_W-1:0]  rx_channel;
    logic [RAND_W-1:0] rand_prime_start;
    logic [RAND_W-1:0] rand_rate;
    logic [RAND_W-1:0] rand_index;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              match;
    logic [HOP_W-1:0]  hop_count;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSTART,
    ST_TEST,
    ST_TDIV,
    ST_RATE,
    ST_SUM,
    ST_IDX,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* rtl/modular_clock_channel_hopper.sv */
// A plain hop reduces index plus rate by the prime and redraws the index if it is out of range.
// Init and epoch hops add random-word draws and a prime search by trial division, all on one
// shared remainder unit. The block takes one word at a time; the next word is taken in the
// cycle after the result is taken. Reset (rst_n low, synchronous): counters, index and
// prime clear, rate goes to 2, channel count to 16, compare mode off.
`default_nettype none

module modular_clock_channel_hopper (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mcch_pkg::in_word_t                   in_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mcch_pkg::out_word_t                  out_word,
  input  logic                                 cfg_we,
  input  logic [mcch_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcch_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import mcch_pkg::*;

  state_t               state_r, state_nxt;
  in_word_t             item_r, item_nxt;
  logic [ROUND_W-1:0]   round_r, round_nxt;
  logic [CNT_W-1:0]     prime_r, prime_nxt;
  logic [CHAN_W-1:0]    idx_r, idx_nxt;
  logic [CHAN_W-1:0]    rate_r, rate_nxt;
  logic [HOP_W-1:0]     hop_cnt_r, hop_cnt_nxt;
  logic [CNT_W-1:0]     chan_cnt_r, chan_cnt_nxt;
  logic                 cmp_r, cmp_nxt;
  logic [BOUND_W-1:0]   x_r, x_nxt;
  logic [TRIAL_W-1:0]   d_r, d_nxt;
  logic                 pass2_r, pass2_nxt;

  // shared remainder unit
  logic [RAND_W-1:0]    div_q_r, div_q_nxt;
  logic [CNT_W-1:0]     div_rem_r, div_rem_nxt;
  logic [CNT_W-1:0]     div_d_r, div_d_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 mod_go;
  logic                 mod_long;
  logic [RAND_W-1:0]    mod_a;
  logic [CNT_W-1:0]     mod_b;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_step;
  logic                 div_done;

  logic [CNT_W-1:0]     n_eff;
  logic [BOUND_W-1:0]   n2;
  logic [ROUND_W:0]     round_inc;
  logic [CNT_W-1:0]     sum_cur;
  logic [CHAN_W-1:0]    rate_new;
  logic [CNT_W-1:0]     sum_new;
  logic [BOUND_W-1:0]   d_sq;

  always_comb begin
    if (chan_cnt_r < CNT_W'(CH_MIN)) begin
      n_eff = CNT_W'(CH_MIN);
    end else if (chan_cnt_r > CNT_W'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = chan_cnt_r;
    end
  end

  assign n2        = {n_eff, 1'b0};
  assign round_inc = {1'b0, round_r} + (ROUND_W+1)'(1);
  assign sum_cur   = {1'b0, idx_r} + {1'b0, rate_r};
  assign rate_new  = div_rem_r[CHAN_W-1:0] + RATE_MIN;
  assign sum_new   = {1'b0, idx_r} + {1'b0, rate_new};
  assign d_sq      = BOUND_W'(d_r) * BOUND_W'(d_r);

  // one restoring step per cycle
  assign rem_sh   = {div_rem_r, div_q_r[RAND_W-1]};
  assign rem_step = (rem_sh >= {1'b0, div_d_r}) ? (rem_sh - {1'b0, div_d_r}) : rem_sh;
  assign div_done = (div_cnt_r == '0);

  always_comb begin
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_d_nxt   = div_d_r;
    div_cnt_nxt = div_cnt_r;
    if (mod_go) begin
      div_q_nxt   = mod_long ? mod_a : {mod_a[CNT_W-1:0], {(RAND_W-CNT_W){1'b0}}};
      div_rem_nxt = '0;
      div_d_nxt   = mod_b;
      div_cnt_nxt = mod_long ? DIV_CNT_W'(RAND_W) : DIV_CNT_W'(CNT_W);
    end else if (!div_done) begin
      div_q_nxt   = {div_q_r[RAND_W-2:0], 1'b0};
      div_rem_nxt = rem_step[CNT_W-1:0];
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    round_nxt    = round_r;
    prime_nxt    = prime_r;
    idx_nxt      = idx_r;
    rate_nxt     = rate_r;
    hop_cnt_nxt  = hop_cnt_r;
    chan_cnt_nxt = chan_cnt_r;
    cmp_nxt      = cmp_r;
    x_nxt        = x_r;
    d_nxt        = d_r;
    pass2_nxt    = pass2_r;
    mod_go       = 1'b0;
    mod_long     = 1'b0;
    mod_a        = '0;
    mod_b        = '0;

    if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: chan_cnt_nxt = cfg_wdata;
        REG_COMPARE_MODE:  cmp_nxt      = cfg_wdata[0];
        default:           ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_word;
          if (in_word.op == OP_INIT) begin
            round_nxt   = '0;
            hop_cnt_nxt = '0;
            x_nxt       = {1'b0, n_eff};
            d_nxt       = TRIAL_W'(2);
            pass2_nxt   = 1'b0;
            state_nxt   = ST_TEST;
          end else begin
            hop_cnt_nxt = hop_cnt_r + HOP_W'(1);
            if (round_inc > {1'b0, prime_r, 1'b0}) begin
              // new epoch: draw the search start first
              round_nxt = '0;
              mod_go    = 1'b1;
              mod_long  = 1'b1;
              mod_a     = in_word.rand_prime_start;
              mod_b     = n_eff;
              state_nxt = ST_PSTART;
            end else begin
              round_nxt = round_inc[ROUND_W-1:0];
              mod_go    = 1'b1;
              mod_a     = RAND_W'(sum_cur);
              mod_b     = prime_r;
              state_nxt = ST_SUM;
            end
          end
        end
      end

      ST_PSTART: begin
        if (div_done) begin
          x_nxt     = {1'b0, div_rem_r} + {1'b0, n_eff};
          d_nxt     = TRIAL_W'(2);
          pass2_nxt = 1'b0;
          state_nxt = ST_TEST;
        end
      end

      ST_TEST: begin
        if (x_r >= n2) begin
          if (!pass2_r) begin
            // nothing above the random start, search again from n
            x_nxt     = {1'b0, n_eff};
            pass2_nxt = 1'b1;
          end else begin
            prime_nxt = CNT_W'(n2 - BOUND_W'(1));
            mod_go    = 1'b1;
            mod_long  = 1'b1;
            mod_a     = item_r.rand_rate;
            mod_b     = n_eff - CNT_W'(2);
            state_nxt = ST_RATE;
          end
        end else if (d_sq > x_r) begin
          prime_nxt = x_r[CNT_W-1:0];
          mod_go    = 1'b1;
          mod_long  = 1'b1;
          mod_a     = item_r.rand_rate;
          mod_b     = n_eff - CNT_W'(2);
          state_nxt = ST_RATE;
        end else begin
          mod_go    = 1'b1;
          mod_a     = RAND_W'(x_r[CNT_W-1:0]);
          mod_b     = CNT_W'(d_r);
          state_nxt = ST_TDIV;
        end
      end

      ST_TDIV: begin
        if (div_done) begin
          if (div_rem_r == '0) begin
            x_nxt = x_r + BOUND_W'(1);
            d_nxt = TRIAL_W'(2);
          end else begin
            d_nxt = d_r + TRIAL_W'(1);
          end
          state_nxt = ST_TEST;
        end
      end

      ST_RATE: begin
        if (div_done) begin
          rate_nxt = rate_new;
          mod_go   = 1'b1;
          if (item_r.op == OP_INIT) begin
            mod_long  = 1'b1;
            mod_a     = item_r.rand_index;
            mod_b     = n_eff;
            state_nxt = ST_IDX;
          end else begin
            mod_a     = RAND_W'(sum_new);
            mod_b     = prime_r;
            state_nxt = ST_SUM;
          end
        end
      end

      ST_SUM: begin
        if (div_done) begin
          if (div_rem_r >= n_eff) begin
            // index beyond the channel set, replace it
            mod_go    = 1'b1;
            mod_long  = 1'b1;
            mod_a     = item_r.rand_index;
            mod_b     = n_eff;
            state_nxt = ST_IDX;
          end else begin
            idx_nxt   = div_rem_r[CHAN_W-1:0];
            state_nxt = ST_OUT;
          end
        end
      end

      ST_IDX: begin
        if (div_done) begin
          idx_nxt   = div_rem_r[CHAN_W-1:0];
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      round_r    <= '0;
      prime_r    <= '0;
      idx_r      <= '0;
      rate_r     <= RATE_RST;
      hop_cnt_r  <= '0;
      chan_cnt_r <= CHANNEL_COUNT_RST;
      cmp_r      <= 1'b0;
      pass2_r    <= 1'b0;
      div_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      round_r    <= round_nxt;
      prime_r    <= prime_nxt;
      idx_r      <= idx_nxt;
      rate_r     <= rate_nxt;
      hop_cnt_r  <= hop_cnt_nxt;
      chan_cnt_r <= chan_cnt_nxt;
      cmp_r      <= cmp_nxt;
      pass2_r    <= pass2_nxt;
      div_cnt_r  <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    x_r       <= x_nxt;
    d_r       <= d_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    out_word.channel   = idx_r;
    out_word.match     = (item_r.op == OP_HOP) && cmp_r &&
                         (item_r.rx_channel == {1'b0, idx_r});
    out_word.hop_count = hop_cnt_r;
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    mod_go |-> (mod_b != '0))
    else $error("remainder unit started with zero divisor");

  a_div_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (div_cnt_r != '0) |-> in_stall)
    else $error("input open while remainder unit busy");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, round_r} <= {1'b0, prime_r, 1'b0}))
    else $error("round counter beyond twice the prime");

  a_chan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, idx_r} < n_eff))
    else $error("channel beyond channel count");

  a_hop_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_word.op == OP_HOP)) |=>
      (hop_cnt_r == $past(hop_cnt_r) + HOP_W'(1)))
    else $error("hop count did not advance by one");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcch_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_WORDS  = 900;
  localparam int IDLE_PCT    = 31;
  localparam int HOLD_CYCLES = 600;
  localparam int DIR_ROWS    = 27;

  typedef enum logic [1:0] {ROW_REG, ROW_PREDICT, ROW_KNOWN} row_kind_t;

  // Known rows are init words: match and hop_count are zero, channel is given.
  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    in_word_t               word;
    logic [CHAN_W-1:0]      known_chan;
  } dir_row_t;

  localparam in_word_t NO_WORD = '0;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  modular_clock_channel_hopper u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hopper state as the block should hold it
  logic [CNT_W-1:0]   m_chan_cnt;
  logic               m_cmp;
  logic [ROUND_W-1:0] m_round;
  logic [CNT_W-1:0]   m_prime;
  logic [CNT_W-1:0]   m_index;
  logic [CHAN_W-1:0]  m_rate;
  logic [HOP_W-1:0]   m_hops;

  out_word_t pending_hops[$];

  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned init_count;
  int unsigned epoch_count;
  int unsigned match_count;
  int unsigned fallbacks;
  int unsigned cycles;
  bit          quiet;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_REG, REG_CHANNEL_COUNT, 9'd8, NO_WORD, 8'd0},
    // hop straight out of reset; start offset 6 lands on 14, past the last prime below 16
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h000, 16'h0006, 16'hffff, 16'hffff}, 8'd0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 9'd0,
      '{OP_INIT, 9'h1ff, 16'hffff, 16'hffff, 16'hffff}, 8'd7},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h000, 16'h0000, 16'h0000, 16'h0000}, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h1ff, 16'hffff, 16'hffff, 16'hffff}, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h155, 16'haaaa, 16'h5555, 16'haaaa}, 8'd0},
    '{ROW_REG, REG_CHANNEL_COUNT, 9'd0, NO_WORD, 8'd0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 9'd0,
      '{OP_INIT, 9'h0aa, 16'h5555, 16'h0000, 16'h0000}, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h1ff, 16'hffff, 16'hffff, 16'hffff}, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h000, 16'h0000, 16'h0000, 16'h0000}, 8'd0},
    '{ROW_REG, REG_COMPARE_MODE, 9'd1, NO_WORD, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h000, 16'h1234, 16'h4321, 16'h0000}, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h001, 16'h0001, 16'h0001, 16'h0001}, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h002, 16'h0002, 16'h0002, 16'h0002}, 8'd0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 9'd0,
      '{OP_INIT, 9'h002, 16'h0000, 16'h0000, 16'h0005}, 8'd2},
    '{ROW_REG, REG_CHANNEL_COUNT, 9'd511, NO_WORD, 8'd0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 9'd0,
      '{OP_INIT, 9'h0ff, 16'hffff, 16'hffff, 16'hffff}, 8'd255},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h0ff, 16'hffff, 16'hffff, 16'hffff}, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h1ff, 16'h0000, 16'h0000, 16'h0000}, 8'd0},
    '{ROW_REG, REG_CHANNEL_COUNT, 9'd256, NO_WORD, 8'd0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 9'd0,
      '{OP_INIT, 9'h000, 16'h0000, 16'h0000, 16'h0100}, 8'd0},
    '{ROW_REG, REG_CHANNEL_COUNT, 9'd2, NO_WORD, 8'd0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 9'd0,
      '{OP_INIT, 9'h001, 16'h0000, 16'hffff, 16'h0007}, 8'd1},
    '{ROW_REG, REG_COMPARE_MODE, 9'd0, NO_WORD, 8'd0},
    '{ROW_PREDICT, REG_CHANNEL_COUNT, 9'd0,
      '{OP_HOP, 9'h1ff, 16'hffff, 16'hffff, 16'hffff}, 8'd0},
    '{ROW_REG, REG_CHANNEL_COUNT, 9'd257, NO_WORD, 8'd0},
    '{ROW_KNOWN, REG_CHANNEL_COUNT, 9'd0,
      '{OP_INIT, 9'h000, 16'h0000, 16'h0000, 16'h01ff}, 8'd255}
  };

  function automatic int unsigned usable_channels();
    int unsigned n;
    n = m_chan_cnt;
    if (n < CH_MIN) n = CH_MIN;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    return n;
  endfunction

  function automatic bit is_prime_num(int unsigned x);
    if (x < 2) return 1'b0;
    for (int unsigned d = 2; d * d <= x; d++) begin
      if (x % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // First prime in [from, bound), zero when there is none
  function automatic int unsigned first_prime(int unsigned from, int unsigned bound);
    for (int unsigned x = from; x < bound; x++) begin
      if (is_prime_num(x)) return x;
    end
    return 0;
  endfunction

  function automatic int unsigned choose_prime(int unsigned from, int unsigned n);
    int unsigned p;
    p = first_prime(from, 2 * n);
    if (p == 0) begin
      fallbacks++;
      p = first_prime(n, 2 * n);
    end
    if (p == 0) p = 2 * n - 1;
    return p;
  endfunction

  function automatic out_word_t advance_hopper(in_word_t w);
    int unsigned n;
    out_word_t   r;
    n = usable_channels();
    r.match = 1'b0;
    if (w.op == OP_INIT) begin
      init_count++;
      m_round = '0;
      m_hops  = '0;
      m_prime = CNT_W'(choose_prime(n, n));
      m_index = CNT_W'(32'(w.rand_index) % n);
      m_rate  = CHAN_W'((32'(w.rand_rate) % (n - 2)) + 2);
    end else begin
      m_round = m_round + 1'b1;
      m_hops  = m_hops + 1'b1;
      if (32'(m_round) > 2 * 32'(m_prime)) begin
        epoch_count++;
        m_round = '0;
        m_prime = CNT_W'(choose_prime((32'(w.rand_prime_start) % n) + n, n));
        m_rate  = CHAN_W'((32'(w.rand_rate) % (n - 2)) + 2);
      end
      m_index = CNT_W'((32'(m_index) + 32'(m_rate)) % 32'(m_prime));
      if (32'(m_index) >= n) m_index = CNT_W'(32'(w.rand_index) % n);
      if (m_cmp && w.rx_channel == m_index) r.match = 1'b1;
    end
    r.channel   = m_index[CHAN_W-1:0];
    r.hop_count = m_hops;
    return r;
  endfunction

  function automatic in_word_t random_word(int unsigned n);
    in_word_t w;
    w.op = ($urandom_range(0, 39) == 0) ? OP_INIT : OP_HOP;
    // half the time pick a channel that can actually match
    if ($urandom_range(0, 1) == 1) w.rx_channel = CNT_W'($urandom_range(0, n - 1));
    else w.rx_channel = CNT_W'($urandom);
    w.rand_prime_start = RAND_W'($urandom);
    w.rand_rate        = RAND_W'($urandom);
    w.rand_index       = RAND_W'($urandom);
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit known,
                           input logic [CHAN_W-1:0] known_chan);
    out_word_t hop_res;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hop_res = advance_hopper(w);
    if (known) begin
      hop_res.channel   = known_chan;
      hop_res.match     = 1'b0;
      hop_res.hop_count = '0;
    end
    pending_hops.push_back(hop_res);
    words_sent++;
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hops.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    if (idx == REG_CHANNEL_COUNT) m_chan_cnt = CNT_W'(val);
    else m_cmp = val[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_hops.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word: expected none, got channel %0d match %0d hop_count %0d",
                 $time, out_word.channel, out_word.match, out_word.hop_count);
      end else begin
        want = pending_hops.pop_front();
        if (want.match) match_count++;
        if (out_word.channel !== want.channel)
          report_field("channel", 32'(want.channel), 32'(out_word.channel));
        if (out_word.match !== want.match)
          report_field("match", 32'(want.match), 32'(out_word.match));
        if (out_word.hop_count !== want.hop_count)
          report_field("hop_count", want.hop_count, out_word.hop_count);
      end
    end
  end

  initial begin : result_stall
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      // hold off once long enough to back the block up into its input
      if (!held && results_seen >= 250) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_hops.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    in_word_t    w;
    int unsigned n_pick;
    int unsigned n_eff;
    int unsigned phase_len;
    int unsigned rand_sent;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_CHANNEL_COUNT;
    cfg_wdata    = '0;
    quiet        = 1'b0;
    words_sent   = 0;
    results_seen = 0;
    fail_count   = 0;
    init_count   = 0;
    epoch_count  = 0;
    match_count  = 0;
    fallbacks    = 0;
    cycles       = 0;
    m_chan_cnt   = CHANNEL_COUNT_RST;
    m_cmp        = 1'b0;
    m_round      = '0;
    m_prime      = '0;
    m_index      = '0;
    m_rate       = RATE_RST;
    m_hops       = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      case (row.kind)
        ROW_REG:   write_reg(row.reg_idx, row.reg_val);
        ROW_KNOWN: send_word(row.word, 1'b1, row.known_chan);
        default:   send_word(row.word, 1'b0, '0);
      endcase
    end

    rand_sent = 0;
    while (rand_sent < RAND_WORDS) begin
      case ($urandom_range(0, 7))
        0:       n_pick = $urandom_range(0, 2);
        1:       n_pick = CH_MIN;
        2:       n_pick = $urandom_range(MAX_CHANNELS + 1, 511);
        3:       n_pick = MAX_CHANNELS;
        4, 5:    n_pick = $urandom_range(4, 40);
        6:       n_pick = $urandom_range(4, 511);
        default: n_pick = $urandom_range(4, 16);
      endcase
      write_reg(REG_CHANNEL_COUNT, n_pick);
      write_reg(REG_COMPARE_MODE, $urandom_range(0, 1));
      n_eff     = usable_channels();
      phase_len = $urandom_range(30, 150);
      // skip the init now and then so the old prime carries over into the new count
      if ($urandom_range(0, 3) != 0) begin
        w    = random_word(n_eff);
        w.op = OP_INIT;
        send_word(w, 1'b0, '0);
        rand_sent++;
      end
      for (int unsigned k = 0; k < phase_len && rand_sent < RAND_WORDS; k++) begin
        send_word(random_word(n_eff), 1'b0, '0);
        rand_sent++;
        quiet = (rand_sent >= 400 && rand_sent < 550);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    $display("hopper run: %0d words, %0d results, %0d inits, %0d epochs, %0d matches",
             words_sent, results_seen, init_count, epoch_count, match_count);
    $display("prime search restarts from n: %0d, failures: %0d", fallbacks, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/mcch_pkg.sv
rtl/modular_clock_channel_hopper.sv
sim/tb_top.sv
